// ===== rtl/core/adpcm_pkg.sv =====
// Package for the 3-bit ADPCM sample decoder.
// Holds the predictor operand struct and the coefficient pair tables.
// No dependencies.
package adpcm_pkg;

  localparam int unsigned TapW  = 32;
  localparam int unsigned CoefW = 18;

  // Operands handed from the channel state to the predictor datapath.
  typedef struct packed {
    logic signed [TapW-1:0] tap_recent;
    logic signed [TapW-1:0] tap_older;
    logic [1:0]             filter_sel;
    logic [3:0]             shift;
    logic signed [2:0]      residual;
  } pred_in_t;

  localparam logic signed [CoefW-1:0] CoefZero    = 18'sh00000;
  localparam logic signed [CoefW-1:0] CoefRecent1 = 18'sh0F000;
  localparam logic signed [CoefW-1:0] CoefRecent2 = 18'sh1E800;
  localparam logic signed [CoefW-1:0] CoefRecent3 = 18'sh1CC00;
  localparam logic signed [CoefW-1:0] CoefOlder2  = -18'sh0F000;
  localparam logic signed [CoefW-1:0] CoefOlder3  = -18'sh0D000;

  // Weight applied to the most recent tap.
  function automatic logic signed [CoefW-1:0] coef_recent(input logic [1:0] sel);
    logic signed [CoefW-1:0] c;
    case (sel)
      2'd1:    c = CoefRecent1;
      2'd2:    c = CoefRecent2;
      2'd3:    c = CoefRecent3;
      default: c = CoefZero;
    endcase
    return c;
  endfunction

  // Weight applied to the older tap.
  function automatic logic signed [CoefW-1:0] coef_older(input logic [1:0] sel);
    logic signed [CoefW-1:0] c;
    case (sel)
      2'd2:    c = CoefOlder2;
      2'd3:    c = CoefOlder3;
      default: c = CoefZero;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/adpcm_predictor.sv =====
// Predictor datapath of the ADPCM decoder: forms the new tap from two taps,
// a coefficient pair, a shift and a residual. Depends on adpcm_pkg.
module adpcm_predictor
  import adpcm_pkg::*;
(
  input  pred_in_t               pred_i,
  output logic signed [TapW-1:0] tap_o
);

  logic signed [TapW+CoefW-1:0] prod_recent;
  logic signed [TapW+CoefW-1:0] prod_older;
  logic signed [TapW-1:0]       pred_sum;
  logic signed [TapW-1:0]       pred_shr;
  logic signed [TapW-1:0]       res_ext;
  logic signed [TapW-1:0]       res_shl;

  assign prod_recent = pred_i.tap_recent * coef_recent(pred_i.filter_sel);
  assign prod_older  = pred_i.tap_older * coef_older(pred_i.filter_sel);

  // Products and their sum wrap at the tap width.
  assign pred_sum = prod_recent[TapW-1:0] + prod_older[TapW-1:0];
  assign pred_shr = pred_sum >>> 16;

  assign res_ext = TapW'(pred_i.residual);
  assign res_shl = res_ext << pred_i.shift;

  assign tap_o = pred_shr + res_shl;

endmodule

// ===== rtl/core/adpcm_sample_decoder.sv =====
// Top level of the 3-bit ADPCM sample decoder: input register, channel state,
// predictor and saturating output register. Depends on adpcm_pkg, adpcm_predictor.
// An input item moves from the input register into the result register, whose
// sample shows on the master side. Throughput: one sample per cycle unless the
// master side stalls; tap feedback through the predictor closes combinationally.
// Reset (rst_ni low, asynchronous) empties both registers and clears taps,
// accumulator, group counter, shift and coefficient selection.
module adpcm_sample_decoder
  import adpcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: seed[7:0], header[13:8], residual[16:14], zero fill [23:17]
  input  logic [23:0] s_axis_tdata,
  // tuser: start_req[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: sample[15:0]
  output logic [15:0] m_axis_tdata
);

  localparam logic signed [TapW-1:0] SatMax = 32'sd32767;
  localparam logic signed [TapW-1:0] SatMin = -32'sd32768;

  // One captured input item.
  typedef struct packed {
    logic              start;
    logic [7:0]        seed;
    logic [5:0]        header;
    logic signed [2:0] residual;
  } in_item_t;

  in_item_t               in_q;
  logic                   in_valid_q;
  logic                   out_valid_q;
  logic [15:0]            sample_q, sample_d;

  logic signed [TapW-1:0] tap_recent_q, tap_recent_d;
  logic signed [TapW-1:0] tap_older_q, tap_older_d;
  logic signed [TapW-1:0] acc_q, acc_d;
  logic [1:0]             group_q, group_d;
  logic [3:0]             shift_q, shift_d;
  logic [1:0]             fsel_q, fsel_d;

  logic                   advance;
  logic                   in_xfer;
  logic [1:0]             group_eff;
  logic signed [TapW-1:0] acc_base;
  logic signed [15:0]     seed_val;
  pred_in_t               pred;
  logic signed [TapW-1:0] tap_new;

  // The held item moves into the result register whenever that register is
  // empty or its sample is being taken in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.start    <= s_axis_tuser;
      in_q.seed     <= s_axis_tdata[7:0];
      in_q.header   <= s_axis_tdata[13:8];
      in_q.residual <= s_axis_tdata[16:14];
    end
  end

  // A start item reseeds the channel before its own residual is decoded:
  // taps cleared, group counter back to "header due".
  assign seed_val  = {in_q.seed, 8'h00};
  assign acc_base  = in_q.start ? TapW'(seed_val) : acc_q;
  assign group_eff = in_q.start ? 2'd0 : group_q;

  always_comb begin
    shift_d = shift_q;
    fsel_d  = fsel_q;
    if (group_eff == 2'd0) begin
      shift_d = in_q.header[3:0];
      fsel_d  = in_q.header[5:4];
    end
  end

  assign group_d = group_eff - 2'd1;

  assign pred.tap_recent = in_q.start ? '0 : tap_recent_q;
  assign pred.tap_older  = in_q.start ? '0 : tap_older_q;
  assign pred.filter_sel = fsel_d;
  assign pred.shift      = shift_d;
  assign pred.residual   = in_q.residual;

  adpcm_predictor u_predictor (
    .pred_i (pred),
    .tap_o  (tap_new)
  );

  assign tap_older_d  = pred.tap_recent;
  assign tap_recent_d = tap_new;
  assign acc_d        = acc_base + tap_new;

  // Only the output saturates; the accumulator keeps its wrapped value.
  always_comb begin
    if (acc_d > SatMax) begin
      sample_d = SatMax[15:0];
    end else if (acc_d < SatMin) begin
      sample_d = SatMin[15:0];
    end else begin
      sample_d = acc_d[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_recent_q <= '0;
      tap_older_q  <= '0;
      acc_q        <= '0;
      group_q      <= '0;
      shift_q      <= '0;
      fsel_q       <= '0;
    end else if (advance) begin
      tap_recent_q <= tap_recent_d;
      tap_older_q  <= tap_older_d;
      acc_q        <= acc_d;
      group_q      <= group_d;
      shift_q      <= shift_d;
      fsel_q       <= fsel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_q <= sample_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sample_q;

  // A full input register facing a stalled output must refuse new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline is blocked");

  // Every item that advances shows up as a valid sample in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("advanced item produced no sample");

  // A start item restarts the group of four and leaves a cleared older tap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.start |=> group_q == 2'd3 && tap_older_q == '0)
    else $error("start item did not reset group counter or taps");

endmodule

// ===== bench/adpcm_sample_decoder_tb.sv =====
// Self-checking testbench for the 3-bit ADPCM sample decoder.
// Holds a sample checker class with its own channel state and the bench top.
// Depends only on the adpcm_sample_decoder RTL and its package.
module adpcm_sample_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung. The longest
  // intended quiet stretch is the receiver hold-off below.
  localparam int QuietLimit    = 2000;
  localparam int HoldCycles    = 200;
  localparam int ItemsPerPhase = 350;
  // Room for the pipeline to empty, plus margin for the final quiet check.
  localparam int TailCycles    = 6;

  // Tracks the decoder's channel state and queues the sample each accepted
  // transfer must produce. Samples come back strictly in order.
  class sample_checker;
    logic [31:0] tap_recent;
    logic [31:0] tap_older;
    logic [31:0] acc;
    logic [1:0]  group_left;
    logic [1:0]  coef_sel;
    logic [3:0]  shift;
    logic [15:0] expected_samples[$];
    int          errors;
    int          checked;
    int          starts;
    int          clipped;

    function new();
      tap_recent = '0;
      tap_older  = '0;
      acc        = '0;
      group_left = '0;
      coef_sel   = '0;
      shift      = '0;
      errors     = 0;
      checked    = 0;
      starts     = 0;
      clipped    = 0;
    endfunction

    // Advances the channel by one input transfer and queues its sample.
    function void accept_item(bit start, bit [7:0] seed, bit [5:0] header, bit [2:0] residual);
      logic [31:0]        c1;
      logic [31:0]        c2;
      logic [31:0]        sum;
      logic [31:0]        pred;
      logic [31:0]        step;
      logic signed [31:0] level;
      logic [15:0]        sample;
      if (start) begin
        acc        = {{16{seed[7]}}, seed, 8'h00};
        tap_recent = '0;
        tap_older  = '0;
        group_left = '0;
        starts++;
      end
      // A new header is latched on the first sample of each group of four.
      if (group_left == 2'd0) begin
        shift    = header[3:0];
        coef_sel = header[5:4];
      end
      group_left = group_left - 2'd1;
      case (coef_sel)
        2'd1: begin
          c1 = 32'h0000_F000;
          c2 = 32'h0000_0000;
        end
        2'd2: begin
          c1 = 32'h0001_E800;
          c2 = 32'hFFFF_1000;
        end
        2'd3: begin
          c1 = 32'h0001_CC00;
          c2 = 32'hFFFF_3000;
        end
        default: begin
          c1 = 32'h0000_0000;
          c2 = 32'h0000_0000;
        end
      endcase
      // All 32-bit operands, so products and the sum wrap as the hardware does.
      sum  = tap_older * c2 + tap_recent * c1;
      pred = $signed(sum) >>> 16;
      step = pred + ({{29{residual[2]}}, residual} << shift);
      tap_older  = tap_recent;
      tap_recent = step;
      acc        = acc + step;
      level      = acc;
      if (level > 32767) begin
        sample = 16'h7FFF;
        clipped++;
      end else if (level < -32768) begin
        sample = 16'h8000;
        clipped++;
      end else begin
        sample = acc[15:0];
      end
      expected_samples.push_back(sample);
    endfunction

    // Compares one sample transfer against the oldest queued sample.
    function void check_sample(logic [15:0] got);
      logic [15:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample: expected none, actual %0d", $signed(got));
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (got !== want) begin
        $error("sample: expected %0d, actual %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: seed[7:0], header[13:8], residual[16:14], zero fill [23:17]
  logic [23:0] s_axis_tdata = '0;
  // tuser: start_req[0]
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: sample[15:0]
  logic [15:0] m_axis_tdata;

  sample_checker checker_h = new();

  // Idle mix for the current phase, in percent of cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;
  int hold_left = 0;
  int sent_items = 0;
  int quiet_cycles = 0;

  adpcm_sample_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls at the phase's rate, or a long counted hold-off
  // when one is requested. The hold-off lets the sender fill the pipeline
  // so that the decoder has to stall its input.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output side: every sample transfer is checked as it happens. Values are
  // read at the edge before any nonblocking update of this step lands.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      checker_h.check_sample(m_axis_tdata);
    end
  end

  // Watchdog: counts cycles in which neither side moves a transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d quiet cycles, %0d samples outstanding",
               quiet_cycles, checker_h.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Offers one item, after a random idle gap, and returns at the edge where
  // the transfer happens. Valid stays high on return so that back-to-back
  // items need no extra assignment in the same step.
  task automatic send_item(bit start, bit [7:0] seed, bit [5:0] header, int residual);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, residual[2:0], header, seed};
    s_axis_tuser  <= start;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    checker_h.accept_item(start, seed, header, residual[2:0]);
    sent_items++;
  endtask

  // Stops offering and waits until every queued sample has come back.
  task automatic drain_samples();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (checker_h.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One well-formed channel: a start with a random seed followed by samples.
  // Shifts lean small so that the taps and accumulator stay in range for
  // long stretches; large shifts still show up to drive clipping.
  task automatic run_channel();
    int          len;
    bit [3:0]    shift;
    len = $urandom_range(1, 48);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 85) begin
        shift = 4'($urandom_range(0, 5));
      end else begin
        shift = 4'($urandom_range(0, 15));
      end
      send_item(i == 0, 8'($urandom_range(0, 255)), {2'($urandom_range(0, 3)), shift},
                $urandom_range(0, 7));
    end
  endtask

  initial begin
    int  phase_base;
    bit  held;
    held = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Decoding straight out of reset, without any start: header due first,
    // then ignored headers in the middle of the group, then a new group.
    send_item(1'b0, 8'hA5, 6'h00, 3);
    send_item(1'b0, 8'h5A, 6'h3F, -4);
    send_item(1'b0, 8'h00, 6'h2A, 1);
    send_item(1'b0, 8'hFF, 6'h15, -1);
    send_item(1'b0, 8'h00, 6'h1F, 2);
    // Largest positive seed with the largest shift drives the output into
    // the upper clip; then large negative steps swing through the lower clip
    // while the accumulator keeps its full width.
    send_item(1'b1, 8'h7F, 6'h0F, 3);
    send_item(1'b0, 8'h00, 6'h00, 3);
    send_item(1'b0, 8'h00, 6'h00, -4);
    send_item(1'b0, 8'h00, 6'h00, -4);
    send_item(1'b0, 8'h00, 6'h0F, -4);
    send_item(1'b0, 8'h00, 6'h0F, -4);
    // Most negative seed, first coefficient pair.
    send_item(1'b1, 8'h80, 6'h10, -4);
    send_item(1'b0, 8'h00, 6'h00, 0);
    // Second coefficient pair, including a group boundary into the third.
    send_item(1'b1, 8'h00, 6'h21, 3);
    send_item(1'b0, 8'h00, 6'h00, -4);
    send_item(1'b0, 8'h00, 6'h00, 2);
    send_item(1'b0, 8'h00, 6'h00, -1);
    send_item(1'b0, 8'h00, 6'h33, 3);
    send_item(1'b0, 8'h00, 6'h00, 1);
    // Start in the middle of a group restarts the header count.
    send_item(1'b1, 8'hFF, 6'h3E, -4);
    send_item(1'b0, 8'h00, 6'h00, 3);
    send_item(1'b1, 8'h01, 6'h3F, 3);
    send_item(1'b0, 8'h00, 6'h00, -4);
    drain_samples();

    // Random part in four idle mixes: none, sender only, receiver only, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      phase_base = sent_items;
      while (sent_items - phase_base < ItemsPerPhase) begin
        // Once, with the sender running flat out, hold the receiver off.
        if (phase == 0 && !held && sent_items - phase_base > 100) begin
          hold_request = 1'b1;
          held         = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          run_channel();
        end else begin
          // Noise: arbitrary fields, with a start now and then.
          send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                    6'($urandom_range(0, 63)), $urandom_range(0, 7));
        end
      end
      // The sender pauses here until every sample of the phase is back.
      drain_samples();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d input transfers, %0d samples checked, %0d channel starts",
             sent_items, checker_h.checked, checker_h.starts);
    $display("%0d samples clipped; idle mixes none, sender, receiver and both, one long hold-off",
             checker_h.clipped);
    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
